/* hdl/shbc_pkg.sv */
// Shared constants and types for the sample-hold bit crusher.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package shbc_pkg;

    // default sample width, Q1.(SAMPLE_BITS-1)
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int STEP_W     = 14;
    localparam int BITS_W     = 5;
    localparam int LEVELS_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [STEP_W-1:0] STEP_MIN   = 14'd256;
    localparam logic [STEP_W-1:0] STEP_MAX   = 14'd12800;
    localparam logic [STEP_W-1:0] STEP_RESET = 14'd256;
    localparam logic [STEP_W-1:0] PHASE_ONE  = 14'd256;

    localparam logic [BITS_W-1:0] BITS_MIN   = 5'd2;
    localparam logic [BITS_W-1:0] BITS_MAX   = 5'd16;
    localparam logic [BITS_W-1:0] BITS_RESET = 5'd14;
    localparam int                BITS_LO    = 2;
    localparam int                BITS_HI    = 16;

    localparam logic RIGHT_EN_RESET = 1'b1;

    // subtract-and-count steps that split k into whole periods and remainder
    localparam int KQ_STEPS = 4;
    localparam int QUOT_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_STEP    = 2'd0,
        REG_BIT_DEPTH    = 2'd1,
        REG_RIGHT_ENABLE = 2'd2
    } cfg_reg_t;

    // one strobe per lane stage, driven by the sequencer
    typedef struct packed {
        logic hold;
        logic mult;
        logic div;
        logic shape;
    } shbc_ctrl_t;

endpackage

`default_nettype wire

/* hdl/shbc_lane.sv */
// One crusher lane: phase accumulator, hold register, quantiser and error store.
// Depends on shbc_pkg; stepped by the sequencer in sample_hold_bit_crusher.
`timescale 1ns / 1ps
`default_nettype none

module shbc_lane #(
    parameter int SAMPLE_BITS = shbc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire shbc_pkg::shbc_ctrl_t                ctrl,
    input  wire logic                                lane_en,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire logic [shbc_pkg::STEP_W-1:0]         step,
    input  wire logic [shbc_pkg::LEVELS_W-1:0]       levels,
    input  wire logic [shbc_pkg::BITS_W-1:0]         bits,
    output logic signed [SAMPLE_BITS-1:0]            result
);
    import shbc_pkg::*;

    localparam int N      = SAMPLE_BITS;
    localparam int S_W    = N + 2;
    localparam int PROD_W = S_W + LEVELS_W;
    localparam int K_W    = PROD_W - N;
    localparam int PAT_W  = N + 1;
    localparam int MAG_W  = N + 3;
    localparam int Q_W    = N + 4;
    localparam int E_W    = N + 1;
    localparam int D_W    = N + 5;

    localparam logic signed [D_W-1:0] E_HI = {{(D_W-N){1'b0}}, {N{1'b1}}};
    localparam logic signed [D_W-1:0] E_LO = {{(D_W-N){1'b1}}, {N{1'b0}}};
    localparam logic signed [Q_W-1:0] Y_HI = {{(Q_W-N+1){1'b0}}, {(N-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Y_LO = {{(Q_W-N+1){1'b1}}, {(N-1){1'b0}}};

    // lane state
    logic [STEP_W-1:0]        phase_reg;
    logic signed [N-1:0]      held_reg;
    logic signed [E_W-1:0]    err_reg;

    // stage registers
    logic signed [S_W-1:0]    s_reg;
    logic                     neg_reg;
    logic [S_W-1:0]           a_reg;
    logic [K_W-1:0]           k_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [N-1:0]      result_reg;

    // hold stage
    logic [STEP_W-1:0]        phase_sum;
    logic                     wrap;
    logic signed [N-1:0]      held_new;
    logic signed [S_W-1:0]    s_new;
    logic [S_W-1:0]           a_new;

    assign phase_sum = phase_reg + PHASE_ONE;
    assign wrap      = (phase_sum >= step);
    assign held_new  = wrap ? sample : held_reg;
    assign s_new     = S_W'(held_new) + S_W'(err_reg);
    assign a_new     = s_new[S_W-1] ? $unsigned(-s_new) : $unsigned(s_new);

    // multiply stage: k = (|s| * L + 2^(N-1)) >> N
    logic [PROD_W-1:0]        prod;
    logic [K_W-1:0]           k_new;

    assign prod  = PROD_W'(a_reg) * PROD_W'(levels) + (PROD_W'(1) << (N - 1));
    assign k_new = prod[N +: K_W];

    // divide stage: round(k * 2^N / L) = kq * 2^N + round(kr * 2^N / L).
    // kr / (2^b - 1) is the b-bit block of kr repeated in the fraction.
    logic [K_W-1:0]           rem;
    logic [QUOT_W-1:0]        kq;
    logic [LEVELS_W-1:0]      kr;
    logic [PAT_W-1:0]         pat_tab [BITS_LO:BITS_HI];
    logic [PAT_W-1:0]         pat;
    logic [PAT_W:0]           frac_sum;
    logic [MAG_W-1:0]         mag_new;

    always_comb begin
        rem = k_reg;
        kq  = '0;
        for (int i = 0; i < KQ_STEPS; i++) begin
            if (rem >= K_W'(levels)) begin
                rem = rem - K_W'(levels);
                kq  = kq + 1'b1;
            end
        end
    end

    assign kr = rem[LEVELS_W-1:0];

    for (genvar b = BITS_LO; b <= BITS_HI; b++) begin : g_pat
        for (genvar m = 0; m <= N; m++) begin : g_bit
            localparam int SRC = b - 1 - (m % b);
            assign pat_tab[b][N-m] = kr[SRC];
        end
    end

    always_comb begin
        pat = '0;
        for (int b = BITS_LO; b <= BITS_HI; b++) begin
            if (bits == BITS_W'(b)) begin
                pat = pat_tab[b];
            end
        end
    end

    assign frac_sum = (PAT_W + 1)'(pat) + 1'b1;
    assign mag_new  = (MAG_W'(kq) << N) + MAG_W'(frac_sum[PAT_W:1]);

    // shape stage: restore sign, store error, saturate output
    logic signed [Q_W-1:0]    q_pos;
    logic signed [Q_W-1:0]    q;
    logic signed [D_W-1:0]    diff;
    logic signed [E_W-1:0]    err_next;
    logic signed [N-1:0]      y_new;

    assign q_pos = $signed({1'b0, mag_reg});
    assign q     = neg_reg ? -q_pos : q_pos;
    assign diff  = D_W'(s_reg) - D_W'(q);

    assign err_next = (diff > E_HI) ? E_HI[E_W-1:0] :
                      (diff < E_LO) ? E_LO[E_W-1:0] : diff[E_W-1:0];
    assign y_new    = (q > Y_HI) ? Y_HI[N-1:0] :
                      (q < Y_LO) ? Y_LO[N-1:0] : q[N-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            held_reg  <= '0;
            err_reg   <= '0;
        end else begin
            if (ctrl.hold && lane_en) begin
                phase_reg <= wrap ? (phase_sum - step) : phase_sum;
                held_reg  <= held_new;
            end
            if (ctrl.shape && lane_en) begin
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.hold) begin
            s_reg   <= s_new;
            neg_reg <= s_new[S_W-1];
            a_reg   <= a_new;
        end
        if (ctrl.mult) begin
            k_reg <= k_new;
        end
        if (ctrl.div) begin
            mag_reg <= mag_new;
        end
        if (ctrl.shape) begin
            result_reg <= y_new;
        end
    end

    assign result = result_reg;

    // phase always lands below the largest step after a wrap
    assert property (@(posedge aclk) disable iff (!aresetn) phase_reg < STEP_MAX)
        else $error("shbc_lane: hold phase out of range");

    // a disabled lane keeps its state
    assert property (@(posedge aclk) disable iff (!aresetn)
        !lane_en |=> $stable(held_reg) && $stable(phase_reg) && $stable(err_reg))
        else $error("shbc_lane: state moved while lane disabled");

endmodule

`default_nettype wire

/* hdl/shbc_merge.sv */
// Merge stage: joins both lane results (or the raw right sample) into the
// output register of the master stream. Depends on shbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shbc_merge #(
    parameter int SAMPLE_BITS = shbc_pkg::SAMPLE_BITS_DEF,
    parameter int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire logic                           right_en,
    input  wire logic signed [SAMPLE_BITS-1:0]  y_left,
    input  wire logic signed [SAMPLE_BITS-1:0]  y_right,
    input  wire logic signed [SAMPLE_BITS-1:0]  x_right,
    input  wire logic                           m_tready,
    output logic                                m_tvalid,
    output logic [DATA_W-1:0]                   m_tdata,
    output logic                                out_free
);
    import shbc_pkg::*;

    localparam int N = SAMPLE_BITS;

    logic                    m_tvalid_reg;
    logic [DATA_W-1:0]       m_tdata_reg;
    logic signed [N-1:0]     right_sel;

    // a disabled right lane passes its input through
    assign right_sel = right_en ? y_right : x_right;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= DATA_W'({right_sel, y_left});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // never overwrite a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn) load |-> out_free)
        else $error("shbc_merge: load while output occupied");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !right_en) |=> m_tdata[2*N-1:N] == $past(x_right))
        else $error("shbc_merge: right bypass mismatch");

endmodule

`default_nettype wire

/* hdl/sample_hold_bit_crusher.sv */
// Stereo sample-and-hold bit crusher with first-order error-feedback noise
// shaping. Each frame on the slave stream carries a left and a right signed
// sample; both lanes reduce the sample rate by a Q6.8 hold period, then round
// the held value plus the stored error to 2^bits-1 levels and saturate. A
// disabled right lane passes its raw sample through instead. A new frame is
// accepted once the previous one has been loaded into the output register, so
// the block never works on two frames at once. The sequencer steps both lanes
// through their hold, multiply, divide and shape registers one stage a cycle,
// then waits while the output register is occupied. The lanes keep all state
// in flip-flops, so there is no clearing pass after reset.
// Depends on shbc_pkg, shbc_lane and shbc_merge.
`timescale 1ns / 1ps
`default_nettype none

module sample_hold_bit_crusher #(
    parameter int SAMPLE_BITS = shbc_pkg::SAMPLE_BITS_DEF,
    parameter int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // slave stream: [SAMPLE_BITS-1:0] sample_left, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_right
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [DATA_W-1:0]                  s_tdata,
    // master stream: [SAMPLE_BITS-1:0] out_left, [2*SAMPLE_BITS-1:SAMPLE_BITS] out_right
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [DATA_W-1:0]                       m_tdata,
    // register writes: 0 hold_step, 1 bit_depth, 2 right_enable
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [shbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [shbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import shbc_pkg::*;

    localparam int N = SAMPLE_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HOLD  = 6'b000010,
        ST_MULT  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SHAPE = 6'b010000,
        ST_EMIT  = 6'b100000
    } seq_state_t;

    seq_state_t              state_reg, state_next;

    logic [STEP_W-1:0]       step_reg;
    logic [BITS_W-1:0]       bits_reg;
    logic                    ren_reg;

    logic signed [N-1:0]     x_left_reg;
    logic signed [N-1:0]     x_right_reg;
    logic                    ren_item_reg;

    logic [STEP_W-1:0]       step_c;
    logic [BITS_W-1:0]       bits_c;
    logic [LEVELS_W:0]       levels_full;
    logic [LEVELS_W-1:0]     levels;

    shbc_ctrl_t              ctrl;
    logic                    s_accept;
    logic                    out_free;
    logic                    load;
    logic signed [N-1:0]     y_left;
    logic signed [N-1:0]     y_right;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
            bits_reg <= BITS_RESET;
            ren_reg  <= RIGHT_EN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_HOLD_STEP:    step_reg <= cfg_data[STEP_W-1:0];
                REG_BIT_DEPTH:    bits_reg <= cfg_data[BITS_W-1:0];
                REG_RIGHT_ENABLE: ren_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp settings to their working ranges
    assign step_c = (step_reg < STEP_MIN) ? STEP_MIN :
                    (step_reg > STEP_MAX) ? STEP_MAX : step_reg;
    assign bits_c = (bits_reg < BITS_MIN) ? BITS_MIN :
                    (bits_reg > BITS_MAX) ? BITS_MAX : bits_reg;
    assign levels_full = ((LEVELS_W + 1)'(1) << bits_c) - 1'b1;
    assign levels      = levels_full[LEVELS_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign load     = (state_reg == ST_EMIT) && out_free;

    assign ctrl.hold  = (state_reg == ST_HOLD);
    assign ctrl.mult  = (state_reg == ST_MULT);
    assign ctrl.div   = (state_reg == ST_DIV);
    assign ctrl.shape = (state_reg == ST_SHAPE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_HOLD;
            ST_HOLD:  state_next = ST_MULT;
            ST_MULT:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_SHAPE;
            ST_SHAPE: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // hold the request for the duration of the frame
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_left_reg   <= s_tdata[N-1:0];
            x_right_reg  <= s_tdata[2*N-1:N];
            ren_item_reg <= ren_reg;
        end
    end

    shbc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .lane_en (1'b1),
        .sample  (x_left_reg),
        .step    (step_c),
        .levels  (levels),
        .bits    (bits_c),
        .result  (y_left)
    );

    shbc_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .lane_en (ren_item_reg),
        .sample  (x_right_reg),
        .step    (step_c),
        .levels  (levels),
        .bits    (bits_c),
        .result  (y_right)
    );

    shbc_merge #(.SAMPLE_BITS(SAMPLE_BITS), .DATA_W(DATA_W)) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .right_en (ren_item_reg),
        .y_left   (y_left),
        .y_right  (y_right),
        .x_right  (x_right_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .out_free (out_free)
    );

    // an accepted frame passes through the hold, multiply, divide and shape states to the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> ##5 (state_reg == ST_EMIT))
        else $error("sample_hold_bit_crusher: frame did not reach output stage");

    // a finished frame waits while the output register is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !out_free) |=> (state_reg == ST_EMIT))
        else $error("sample_hold_bit_crusher: result dropped under back-pressure");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for sample_hold_bit_crusher: a directed table of frames and register
// writes, then randomised frames under six register settings, scored by a local model or known values.
// Depends on shbc_pkg and the sample_hold_bit_crusher RTL.
`timescale 1ns / 1ps

module tb_top;

    import shbc_pkg::*;

    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int DW          = 2 * SB;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 400;
    localparam int SEG_FRAMES  = 175;
    localparam int SETTLE      = 20;

    // index with no register behind it; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SB-1:0] S_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [SB-1:0] right;
        logic signed [SB-1:0] left;
    } frame_t;

    typedef enum logic { ROW_FRAME, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        frame_t                 din;
        bit                     known;
        frame_t                 dout;
    } row_t;

    localparam frame_t NIL = '0;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [DW-1:0]          s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [DW-1:0]          m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register shadows and per-lane state of the local model
    logic [STEP_W-1:0]      hold_reg  = STEP_RESET;
    logic [BITS_W-1:0]      depth_reg = BITS_RESET;
    logic                   right_on  = RIGHT_EN_RESET;
    int                     lane_phase [2] = '{0, 0};
    longint                 lane_held  [2] = '{0, 0};
    longint                 lane_err   [2] = '{0, 0};

    frame_t                 crushed_frames [$];
    row_t                   plan [$];

    int                     mismatches    = 0;
    int                     cycle_count   = 0;
    int                     send_idle_pct = 9;
    int                     recv_idle_pct = 53;
    int                     stall_req     = 0;
    int                     stall_seen    = 0;
    int                     stall_cnt     = 0;

    sample_hold_bit_crusher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic frame_t stereo(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
        frame_t f;
        f.left  = l;
        f.right = r;
        return f;
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SB'(int'($urandom_range(511)) - 256);
            default: return SB'($urandom());
        endcase
    endfunction

    // hold, add the stored error, round to the level grid and keep the new error
    function automatic logic signed [SB-1:0] crush_lane(input int c, input logic signed [SB-1:0] x,
                                                         input int step, input longint levels);
        longint s, a, k, mag, q, e;
        bit     neg;
        lane_phase[c] += int'(PHASE_ONE);
        if (lane_phase[c] >= step) begin
            lane_phase[c] -= step;
            lane_held[c]   = longint'(x);
        end
        s   = lane_held[c] + lane_err[c];
        neg = s < 0;
        a   = neg ? -s : s;
        k   = (a * levels + (longint'(1) << (SB - 1))) >> SB;
        mag = (k * (longint'(1) << (SB + 1)) + levels) / (2 * levels);
        q   = neg ? -mag : mag;
        e   = s - q;
        if (e > (longint'(1) << SB) - 1)
            e = (longint'(1) << SB) - 1;
        else if (e < -(longint'(1) << SB))
            e = -(longint'(1) << SB);
        lane_err[c] = e;
        if (q > (longint'(1) << (SB - 1)) - 1)
            q = (longint'(1) << (SB - 1)) - 1;
        else if (q < -(longint'(1) << (SB - 1)))
            q = -(longint'(1) << (SB - 1));
        return SB'(q);
    endfunction

    function automatic frame_t crush_frame(input frame_t din);
        frame_t y;
        int     step, depth;
        longint levels;
        step  = (hold_reg < STEP_MIN) ? int'(STEP_MIN) :
                (hold_reg > STEP_MAX) ? int'(STEP_MAX) : int'(hold_reg);
        depth = (depth_reg < BITS_MIN) ? BITS_LO :
                (depth_reg > BITS_MAX) ? BITS_HI : int'(depth_reg);
        levels = (longint'(1) << depth) - 1;
        y.left  = crush_lane(0, din.left, step, levels);
        y.right = right_on ? crush_lane(1, din.right, step, levels) : din.right;
        return y;
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        if (mismatches < 10)
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_frame(input frame_t din, input bit known, input frame_t dknown);
        frame_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= din;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = crush_frame(din);
        crushed_frames.push_back(known ? dknown : want);
    endtask

    // hold the input until every outstanding result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (crushed_frames.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_HOLD_STEP:    hold_reg  = val[STEP_W-1:0];
            REG_BIT_DEPTH:    depth_reg = val[BITS_W-1:0];
            REG_RIGHT_ENABLE: right_on  = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        frame_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = frame_t'(m_tdata);
            if (crushed_frames.size() == 0) begin
                flag_mismatch("result with no request outstanding", 0, got.left);
            end else begin
                want = crushed_frames.pop_front();
                if (got.left !== want.left)
                    flag_mismatch("out_left", want.left, got.left);
                if (got.right !== want.right)
                    flag_mismatch("out_right", want.right, got.right);
            end
        end
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_cnt  <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int st, bd, re;

        // zero in, zero out; right lane off passes the raw sample
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, NIL, 1'b1, NIL});
        plan.push_back('{ROW_REG, REG_RIGHT_ENABLE, 14'd0, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo('0, S_MIN), 1'b1, stereo('0, S_MIN)});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo('0, S_MAX), 1'b1, stereo('0, S_MAX)});
        plan.push_back('{ROW_REG, REG_RIGHT_ENABLE, 14'd1, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MAX, S_MIN), 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MIN, S_MAX), 1'b0, NIL});
        plan.push_back('{ROW_REG, REG_BIT_DEPTH, 14'd2, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MAX, S_MAX), 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MIN, SB'(1)), 1'b0, NIL});
        // depth below and above range clamps
        plan.push_back('{ROW_REG, REG_BIT_DEPTH, 14'd0, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(24'sh400000, SB'(-1)), 1'b0, NIL});
        plan.push_back('{ROW_REG, REG_BIT_DEPTH, 14'd31, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(SB'(1), SB'(-1)), 1'b0, NIL});
        // hold step below and above range clamps
        plan.push_back('{ROW_REG, REG_HOLD_STEP, 14'd0, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(SB'(123456), SB'(-654321)), 1'b0, NIL});
        plan.push_back('{ROW_REG, REG_HOLD_STEP, 14'h3FFF, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MAX, S_MIN), 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, NIL, 1'b0, NIL});
        plan.push_back('{ROW_REG, REG_HOLD_STEP, 14'd384, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(SB'(1000), SB'(-1000)), 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MAX, S_MAX), 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(S_MIN, S_MIN), 1'b0, NIL});
        plan.push_back('{ROW_REG, REG_SPARE, 14'h3FFF, NIL, 1'b0, NIL});
        plan.push_back('{ROW_FRAME, REG_SPARE, '0, stereo(24'sh555555, 24'shAAAAAA), 1'b0, NIL});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                send_frame(plan[i].din, plan[i].known, plan[i].dout);
            end
        end

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin st = 256;   bd = 16; re = 1; end
                1: begin st = 12800; bd = 2;  re = 1; end
                2: begin
                    st = $urandom_range(2000, 256);
                    bd = $urandom_range(16, 2);
                    re = 0;
                end
                3: begin
                    st = $urandom_range(16383);
                    bd = $urandom_range(31);
                    re = 1;
                end
                4: begin st = 640;   bd = 8;  re = 1; end
                default: begin
                    st = $urandom_range(16383);
                    bd = $urandom_range(31);
                    re = $urandom_range(1);
                end
            endcase
            drain_results();
            write_reg(REG_HOLD_STEP, CFG_DATA_W'(st));
            write_reg(REG_BIT_DEPTH, CFG_DATA_W'(bd));
            write_reg(REG_RIGHT_ENABLE, CFG_DATA_W'(re));
            send_idle_pct  = (seg < 2) ? 9 : (seg < 4) ? 53 : 0;
            recv_idle_pct <= (seg < 2) ? 53 : (seg < 4) ? 9 : 0;
            for (int n = 0; n < SEG_FRAMES; n++) begin
                // stall the result side for a long stretch and keep offering frames
                if (n == 40 && (seg == 1 || seg == 4))
                    stall_req <= stall_req + 1;
                send_frame(stereo(pick_sample(), pick_sample()), 1'b0, NIL);
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (crushed_frames.size() != 0)
            mismatches++;
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
